[sv/mlp_pkg.sv]
`timescale 1ns / 1ps

package mlp_pkg;

    localparam int MAX_HIDDEN    = 64;
    localparam int MAX_INPUTS    = 32;
    localparam int ACT_DEPTH     = 1024;
    localparam int ACT_HALF      = ACT_DEPTH / 2;
    localparam int ACT_IW        = $clog2(ACT_DEPTH);
    localparam int MAG_W         = $clog2(ACT_HALF + 1);
    localparam int WEIGHT_DEPTH  = MAX_HIDDEN * MAX_INPUTS + MAX_HIDDEN;
    localparam int THRESH_DEPTH  = MAX_HIDDEN + 1;
    localparam int WEIGHT_AW     = $clog2(WEIGHT_DEPTH);
    localparam int THRESH_AW     = $clog2(THRESH_DEPTH);
    localparam int FEAT_AW       = $clog2(MAX_INPUTS);
    localparam int HID_AW        = $clog2(MAX_HIDDEN);
    localparam int CNT_W         = $clog2(MAX_HIDDEN + 1);

    localparam logic [31:0] EXP_STEP = 32'd4162825044;

    typedef enum logic [1:0] {
        OP_THRESH  = 2'd0,
        OP_WEIGHT  = 2'd1,
        OP_FEATURE = 2'd2
    } t_op;

    localparam logic REG_NUM_INPUTS = 1'b0;
    localparam logic REG_NUM_HIDDEN = 1'b1;

    typedef struct packed {
        logic              ready;
        logic [15:0]       data;
    } t_act_rsp;

endpackage

[sv/mlp_act_table.sv]
`timescale 1ns / 1ps

module mlp_act_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mlp_pkg::ACT_IW-1:0]  i_rd_idx,
    output mlp_pkg::t_act_rsp           o_rsp
);

    typedef enum logic [5:0] {
        B_LOADP = 6'b000001,
        B_LOADN = 6'b000010,
        B_DIV   = 6'b000100,
        B_WR    = 6'b001000,
        B_MUL   = 6'b010000,
        B_DONE  = 6'b100000
    } t_bstate;

    localparam int QW = 17;

    logic [15:0] mem [mlp_pkg::ACT_DEPTH];

    t_bstate                   r_state;
    logic [mlp_pkg::MAG_W-1:0] r_mag;
    logic [32:0]               r_t;
    logic [64:0]               r_prod;
    logic                      r_neg;
    logic [33:0]               r_rem;
    logic [QW-1:0]             r_low;
    logic [QW-1:0]             r_q;
    logic [4:0]                r_cnt;
    logic [15:0]               r_rd;

    logic [33:0] d;
    logic [48:0] num_p, num_n, num_sel;
    logic [34:0] rem_sh;
    logic [34:0] rem_sub;
    logic [15:0] q_sat;
    logic        wr_en;
    logic [mlp_pkg::ACT_IW-1:0] wr_addr;

    assign d       = 34'h1_0000_0000 + {1'b0, r_t};
    assign num_p   = (49'd1 << 48) + 49'(d >> 1);
    assign num_n   = {r_t, 16'b0} + 49'(d >> 1);
    assign num_sel = (r_state == B_LOADN) ? num_n : num_p;
    assign rem_sh  = {r_rem, r_low[QW-1]};
    assign rem_sub = rem_sh - {1'b0, d};
    assign q_sat   = r_q[QW-1] ? 16'hFFFF : r_q[15:0];

    always_comb begin
        if (r_neg) begin
            wr_en   = (r_mag != '0);
            wr_addr = mlp_pkg::ACT_IW'(mlp_pkg::ACT_HALF - int'(r_mag));
        end else begin
            wr_en   = (int'(r_mag) < mlp_pkg::ACT_HALF);
            wr_addr = mlp_pkg::ACT_IW'(mlp_pkg::ACT_HALF + int'(r_mag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_LOADP;
            r_mag   <= '0;
            r_t     <= 33'h1_0000_0000;
            r_neg   <= 1'b0;
        end else begin
            case (r_state)
                B_LOADP, B_LOADN: begin
                    r_neg   <= (r_state == B_LOADN);
                    r_rem   <= {1'b0, num_sel[48:QW]};
                    r_low   <= num_sel[QW-1:0];
                    r_cnt   <= 5'(QW);
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    if (!rem_sub[34]) begin
                        r_rem <= rem_sub[33:0];
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[33:0];
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_low <= {r_low[QW-2:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) r_state <= B_WR;
                end
                B_WR: begin
                    if (!r_neg) begin
                        r_state <= B_LOADN;
                    end else if (int'(r_mag) == mlp_pkg::ACT_HALF) begin
                        r_state <= B_DONE;
                    end else begin
                        r_prod  <= 65'(r_t) * 65'(mlp_pkg::EXP_STEP);
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_t     <= r_prod[64:32];
                    r_mag   <= r_mag + 1'b1;
                    r_state <= B_LOADP;
                end
                B_DONE: r_state <= B_DONE;
                default: r_state <= B_LOADP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_WR && wr_en) mem[wr_addr] <= q_sat;
        r_rd <= mem[i_rd_idx];
    end

    assign o_rsp.ready = (r_state == B_DONE);
    assign o_rsp.data  = r_rd;

endmodule

[sv/mlp_one_hidden_layer_inference.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                       payload
// request   in         start & !busy                   i_operation i_index i_value i_last
// result    out        o_valid, one cycle, no stall    o_score o_clamped
// config    in         i_cfg_valid & o_cfg_ready       i_cfg_index i_cfg_data
//
// Load requests are stored on acceptance; only the last feature starts an
// evaluation, which runs on one shared 32x32 MAC with a three-stage
// read/multiply/accumulate pipe.
// After reset the activation table is built by a serial divider, with busy
// high; config writes are taken throughout.
// Results cannot be stalled by the receiver.

module mlp_one_hidden_layer_inference (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_index,
    input  logic signed [31:0] i_value,
    input  logic        i_last,
    output logic        o_valid,
    output logic [15:0] o_score,
    output logic        o_clamped,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_THR   = 9'b000000100,
        S_THRW  = 9'b000001000,
        S_MAC   = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_ACT   = 9'b001000000,
        S_RD    = 9'b010000000,
        S_WB    = 9'b100000000
    } t_state;

    localparam int CW = mlp_pkg::CNT_W;
    localparam logic signed [64:0] ACT_LIM  = 65'(mlp_pkg::ACT_HALF) <<< 26;
    localparam logic signed [64:0] ACT_SPAN = 65'(mlp_pkg::ACT_DEPTH) <<< 26;

    logic [31:0] weight_mem [mlp_pkg::WEIGHT_DEPTH];
    logic [31:0] thresh_mem [mlp_pkg::THRESH_DEPTH];
    logic [31:0] feat_mem   [mlp_pkg::MAX_INPUTS];
    logic [15:0] hid_mem    [mlp_pkg::MAX_HIDDEN];

    t_state                          r_state;
    logic [5:0]                      r_num_inputs;
    logic [6:0]                      r_num_hidden;
    logic [CW-1:0]                   r_ni, r_nh, r_len;
    logic [CW-1:0]                   r_i, r_j;
    logic [mlp_pkg::WEIGHT_AW-1:0]   r_wi;
    logic                            r_layer;
    logic                            r_v1, r_v2;
    logic [31:0]                     r_wd, r_fd, r_td;
    logic [15:0]                     r_hd;
    logic signed [63:0]              r_prod;
    logic [63:0]                     r_acc;
    logic                            r_clamp;
    logic [mlp_pkg::ACT_IW-1:0]      r_idx;
    logic                            r_valid;
    logic [15:0]                     r_score;

    mlp_pkg::t_act_rsp act_rsp;

    logic                             issue, accept;
    logic [CW-1:0]                    ni_sat, nh_sat;
    logic [mlp_pkg::THRESH_AW-1:0]    thr_addr;
    logic signed [31:0]               op_b;
    logic signed [64:0]               act_arg;

    mlp_act_table u_act (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .o_rsp    (act_rsp)
    );

    assign accept   = start && !busy;
    assign issue    = (r_state == S_MAC);
    assign ni_sat   = (int'(r_num_inputs) > mlp_pkg::MAX_INPUTS) ?
                      CW'(mlp_pkg::MAX_INPUTS) : CW'(r_num_inputs);
    assign nh_sat   = (int'(r_num_hidden) > mlp_pkg::MAX_HIDDEN) ?
                      CW'(mlp_pkg::MAX_HIDDEN) : CW'(r_num_hidden);
    assign thr_addr = mlp_pkg::THRESH_AW'(r_layer ? r_nh : r_i);
    assign op_b     = r_layer ? $signed({16'b0, r_hd}) : $signed(r_fd);
    assign act_arg  = $signed({r_acc[63], r_acc}) + ACT_LIM;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_inputs <= 6'd27;
            r_num_hidden <= 7'd50;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == mlp_pkg::REG_NUM_INPUTS) r_num_inputs <= i_cfg_data[5:0];
            if (i_cfg_index == mlp_pkg::REG_NUM_HIDDEN) r_num_hidden <= i_cfg_data;
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_operation == mlp_pkg::OP_THRESH && int'(i_index) < mlp_pkg::THRESH_DEPTH)
                thresh_mem[mlp_pkg::THRESH_AW'(i_index)] <= i_value;
            if (i_operation == mlp_pkg::OP_WEIGHT && int'(i_index) < mlp_pkg::WEIGHT_DEPTH)
                weight_mem[mlp_pkg::WEIGHT_AW'(i_index)] <= i_value;
            if (i_operation == mlp_pkg::OP_FEATURE && int'(i_index) < mlp_pkg::MAX_INPUTS)
                feat_mem[mlp_pkg::FEAT_AW'(i_index)] <= i_value;
        end
        if (r_state == S_WB && !r_layer)
            hid_mem[r_i[mlp_pkg::HID_AW-1:0]] <= act_rsp.data;
        r_td <= thresh_mem[thr_addr];
        r_wd <= weight_mem[r_wi];
        r_fd <= feat_mem[r_j[mlp_pkg::FEAT_AW-1:0]];
        r_hd <= hid_mem[r_j[mlp_pkg::HID_AW-1:0]];
        r_prod <= $signed(r_wd) * op_b;
    end

    // sequencer and MAC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_valid <= 1'b0;
            if (r_v2) r_acc <= r_acc + r_prod;
            case (r_state)
                S_INIT: if (act_rsp.ready) r_state <= S_IDLE;
                S_IDLE: begin
                    if (accept && i_operation == mlp_pkg::OP_FEATURE && i_last) begin
                        r_ni    <= ni_sat;
                        r_nh    <= nh_sat;
                        r_i     <= '0;
                        r_wi    <= '0;
                        r_clamp <= 1'b0;
                        r_layer <= (nh_sat == '0);
                        r_state <= S_THR;
                    end
                end
                S_THR: begin
                    r_j     <= '0;
                    r_len   <= r_layer ? r_nh : r_ni;
                    r_state <= S_THRW;
                end
                S_THRW: begin
                    r_acc   <= {{16{r_td[31]}}, r_td, 16'b0};
                    r_state <= (r_len == '0) ? S_DRAIN : S_MAC;
                end
                S_MAC: begin
                    r_j  <= r_j + 1'b1;
                    r_wi <= r_wi + 1'b1;
                    if (r_j + 1'b1 == r_len) r_state <= S_DRAIN;
                end
                S_DRAIN: if (!r_v1 && !r_v2) r_state <= S_ACT;
                S_ACT: begin
                    if (act_arg[64]) begin
                        r_idx   <= '0;
                        r_clamp <= 1'b1;
                    end else if (act_arg >= ACT_SPAN) begin
                        r_idx   <= '1;
                        r_clamp <= 1'b1;
                    end else begin
                        r_idx   <= act_arg[26 +: mlp_pkg::ACT_IW];
                    end
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_WB;
                S_WB: begin
                    if (r_layer) begin
                        r_valid <= 1'b1;
                        r_score <= act_rsp.data;
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 == r_nh) r_layer <= 1'b1;
                        r_state <= S_THR;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_score     = r_score;
    assign o_clamped   = r_clamp;
    assign o_cfg_ready = 1'b1;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == mlp_pkg::OP_FEATURE && i_last) |=> busy)
        else $error("evaluation did not start");
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result while idle");

endmodule
